// ----- rtl/core/sector_obstacle_speed_limiter_top_defines.svh -----
`ifndef SECTOR_OBSTACLE_SPEED_LIMITER_TOP_DEFINES_SVH
`define SECTOR_OBSTACLE_SPEED_LIMITER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SOSL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SOSL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/sosl_pkg.sv -----
`default_nettype none

package sosl_pkg;

  // operation codes
  localparam logic [1:0] OP_HEADER = 2'd0;
  localparam logic [1:0] OP_SAMPLE = 2'd1;
  localparam logic [1:0] OP_END    = 2'd2;
  localparam logic [1:0] OP_CMD    = 2'd3;

  // register indexes
  localparam logic [1:0] REG_SAFETY   = 2'd0;
  localparam logic [1:0] REG_STOP     = 2'd1;
  localparam logic [1:0] REG_MAX_LIN  = 2'd2;
  localparam logic [1:0] REG_MAX_TURN = 2'd3;

  localparam logic [15:0] SAFETY_RST   = 16'd800;
  localparam logic [15:0] STOP_RST     = 16'd300;
  localparam logic [14:0] MAX_LIN_RST  = 15'd800;
  localparam logic [14:0] MAX_TURN_RST = 15'd1000;

  // sector indexes
  localparam logic [1:0] SEC_FRONT = 2'd0;
  localparam logic [1:0] SEC_LEFT  = 2'd1;
  localparam logic [1:0] SEC_RIGHT = 2'd2;
  localparam logic [1:0] SEC_BACK  = 2'd3;
  localparam int         NUM_SEC   = 4;

  localparam logic [15:0] NO_RETURN = 16'hFFFF;

  // sector bounds in binary angle units (65536 per turn); a*360 vs deg*65536
  localparam int TURN = 65536;
  localparam logic signed [15:0] FRONT_MAX = 16'((30 * TURN) / 360);
  localparam logic signed [15:0] SIDE_MIN  = 16'((30 * TURN + 359) / 360);
  localparam logic signed [15:0] SIDE_MAX  = 16'((90 * TURN) / 360);
  localparam logic signed [15:0] BACK_EDGE = 16'((150 * TURN + 359) / 360);

  // restoring divider: quotient fits 16 bits
  localparam int DIV_STEPS = 16;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [15:0] safety;
    logic [15:0] stop;
    logic [14:0] max_lin;
    logic [14:0] max_turn;
  } cfg_t;

  typedef struct packed {
    logic take;
    logic mul;
    logic div_step;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic need_div;
    logic out_free;
  } ctl_sts_t;

  function automatic logic signed [16:0] clamp17(logic signed [16:0] v, logic [14:0] lim);
    logic signed [16:0] l;
    l = $signed({2'b00, lim});
    if (v > l) begin
      return l;
    end else if (v < -l) begin
      return -l;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sector_obstacle_speed_limiter_top.sv -----
// Channel  Handshake                   Payload
// in       in_valid / in_ready         operation, angle_start, angle_step, range_low,
//                                      range_high, range_value, range_finite,
//                                      linear_in, angular_in
// out      out_valid / out_ready       linear_out, angular_out
// cfg      psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// Header, sample and end requests are taken while idle and may arrive back to back.
// A command runs the multiply and finish states, and the 16-step restoring divider
// too when the sector minimum lies between the stop offset and the safety distance.
// rst is synchronous: minima go to no-return, registers to their defaults.
// Results sit in an output register; a command waits in its finish state only while
// an earlier result there is still untaken, and no other request is taken meanwhile.
`default_nettype none

module sector_obstacle_speed_limiter_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         operation,
  input  wire logic signed [15:0] angle_start,
  input  wire logic signed [15:0] angle_step,
  input  wire logic [15:0]        range_low,
  input  wire logic [15:0]        range_high,
  input  wire logic [15:0]        range_value,
  input  wire logic               range_finite,
  input  wire logic signed [15:0] linear_in,
  input  wire logic signed [15:0] angular_in,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      linear_out,
  output logic signed [15:0]      angular_out,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  sosl_pkg::cfg_t     cfg;
  sosl_pkg::ctl_cmd_t cmd;
  sosl_pkg::ctl_sts_t sts;

  sosl_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sosl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (operation),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sosl_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .sts          (sts),
    .operation    (operation),
    .angle_start  (angle_start),
    .angle_step   (angle_step),
    .range_low    (range_low),
    .range_high   (range_high),
    .range_value  (range_value),
    .range_finite (range_finite),
    .linear_in    (linear_in),
    .angular_in   (angular_in),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .linear_out   (linear_out),
    .angular_out  (angular_out)
  );

endmodule

`default_nettype wire

// ----- rtl/core/sosl_regs.sv -----
`default_nettype none

module sosl_regs (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [3:0]     paddr,
  input  wire logic [31:0]    pwdata,
  output logic      [31:0]    prdata,
  output logic                pready,
  output sosl_pkg::cfg_t      cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.safety   <= sosl_pkg::SAFETY_RST;
      cfg.stop     <= sosl_pkg::STOP_RST;
      cfg.max_lin  <= sosl_pkg::MAX_LIN_RST;
      cfg.max_turn <= sosl_pkg::MAX_TURN_RST;
    end else if (wr) begin
      case (paddr[3:2])
        sosl_pkg::REG_SAFETY:   cfg.safety   <= pwdata[15:0];
        sosl_pkg::REG_STOP:     cfg.stop     <= pwdata[15:0];
        sosl_pkg::REG_MAX_LIN:  cfg.max_lin  <= pwdata[14:0];
        sosl_pkg::REG_MAX_TURN: cfg.max_turn <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      sosl_pkg::REG_SAFETY:   prdata = {16'b0, cfg.safety};
      sosl_pkg::REG_STOP:     prdata = {16'b0, cfg.stop};
      sosl_pkg::REG_MAX_LIN:  prdata = {17'b0, cfg.max_lin};
      sosl_pkg::REG_MAX_TURN: prdata = {17'b0, cfg.max_turn};
      default:                prdata = 32'b0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/sosl_ctrl.sv -----
`default_nettype none

module sosl_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic [1:0]          operation,
  output logic                     in_ready,
  input  wire sosl_pkg::ctl_sts_t  sts,
  output sosl_pkg::ctl_cmd_t       cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t                     state, state_next;
  logic [sosl_pkg::CNT_W-1:0] cnt;
  logic                       last_step;

  assign in_ready  = (state == ST_IDLE);
  assign last_step = (cnt == sosl_pkg::CNT_W'(sosl_pkg::DIV_STEPS - 1));

  always_comb begin
    state_next   = state;
    cmd.take     = 1'b0;
    cmd.mul      = 1'b0;
    cmd.div_step = 1'b0;
    cmd.load_out = 1'b0;
    case (state)
      ST_IDLE: begin
        cmd.take = in_valid;
        if (in_valid && operation == sosl_pkg::OP_CMD) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = sts.need_div ? ST_DIV : ST_FIN;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (last_step) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold here while the previous result is still waiting
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_MUL) begin
        cnt <= '0;
      end else if (state == ST_DIV) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/sosl_dp.sv -----
`default_nettype none

module sosl_dp (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire sosl_pkg::cfg_t     cfg,
  input  wire sosl_pkg::ctl_cmd_t cmd,
  output sosl_pkg::ctl_sts_t      sts,
  input  wire logic [1:0]         operation,
  input  wire logic signed [15:0] angle_start,
  input  wire logic signed [15:0] angle_step,
  input  wire logic [15:0]        range_low,
  input  wire logic [15:0]        range_high,
  input  wire logic [15:0]        range_value,
  input  wire logic               range_finite,
  input  wire logic signed [15:0] linear_in,
  input  wire logic signed [15:0] angular_in,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic signed [15:0]      linear_out,
  output logic signed [15:0]      angular_out
);

  logic [15:0] beam_angle;
  logic [15:0] window_low;
  logic [15:0] window_high;
  logic [15:0] bmin [sosl_pkg::NUM_SEC];
  logic [15:0] amin [sosl_pkg::NUM_SEC];
  logic        scan_seen;

  // command operands
  logic signed [15:0] lin_r;
  logic signed [15:0] ang_r;
  logic [15:0]        dist_r;
  logic               red_zero;
  logic               red_div;
  logic [15:0]        rem;
  logic [15:0]        quo;

  // sample path
  logic signed [15:0] a;
  logic               counts;
  logic [sosl_pkg::NUM_SEC-1:0] hit;

  // multiply path
  logic        near_safe;
  logic        zero_f;
  logic        div_f;
  logic [16:0] lin_neg;
  logic [15:0] lin_mag;
  logic [15:0] diff;
  logic [31:0] prod;

  // divider step
  logic [16:0] rem_sh;
  logic        ge;
  logic [16:0] rem_sub;

  // result path
  logic signed [16:0] q17;
  logic signed [16:0] lin_red;
  logic signed [16:0] lin_cl;
  logic [19:0]        left10;
  logic [19:0]        right10;
  logic [19:0]        safe7;
  logic               halve;
  logic signed [16:0] a17;
  logic signed [16:0] ang_h;
  logic signed [16:0] ang_cl;

  assign a      = $signed(beam_angle);
  assign counts = range_finite && (range_value > window_low) && (range_value < window_high);

  assign hit[sosl_pkg::SEC_FRONT] = (a >= -sosl_pkg::FRONT_MAX) && (a <= sosl_pkg::FRONT_MAX);
  assign hit[sosl_pkg::SEC_LEFT]  = (a >= sosl_pkg::SIDE_MIN) && (a <= sosl_pkg::SIDE_MAX);
  assign hit[sosl_pkg::SEC_RIGHT] = (a >= -sosl_pkg::SIDE_MAX) && (a <= -sosl_pkg::SIDE_MIN);
  assign hit[sosl_pkg::SEC_BACK]  = (a >= sosl_pkg::BACK_EDGE) || (a <= -sosl_pkg::BACK_EDGE);

  // reduction only when a scan exists and the chosen sector is inside the safety zone
  assign near_safe = scan_seen && (lin_r != 16'sd0) && (dist_r < cfg.safety);
  assign zero_f    = near_safe && (dist_r <= cfg.stop);
  assign div_f     = near_safe && (dist_r > cfg.stop);
  assign lin_neg   = 17'd0 - {lin_r[15], lin_r};
  assign lin_mag   = lin_r[15] ? lin_neg[15:0] : lin_r;
  assign diff      = dist_r - cfg.stop;
  assign prod      = {16'b0, lin_mag} * {16'b0, diff};

  assign sts.need_div = div_f;
  assign sts.out_free = !out_valid || out_ready;

  // remainder stays below the divisor, so the high product half starts below it too
  assign rem_sh  = {rem, quo[15]};
  assign ge      = (rem_sh >= {1'b0, cfg.safety});
  assign rem_sub = rem_sh - {1'b0, cfg.safety};

  assign q17 = $signed({1'b0, quo});

  always_comb begin
    if (red_zero) begin
      lin_red = 17'sd0;
    end else if (red_div) begin
      lin_red = lin_r[15] ? -q17 : q17;
    end else begin
      lin_red = {lin_r[15], lin_r};
    end
  end

  assign lin_cl = sosl_pkg::clamp17(lin_red, cfg.max_lin);

  // 10*min < 7*safety
  assign left10  = {1'b0, amin[sosl_pkg::SEC_LEFT], 3'b0} + {3'b0, amin[sosl_pkg::SEC_LEFT], 1'b0};
  assign right10 = {1'b0, amin[sosl_pkg::SEC_RIGHT], 3'b0} + {3'b0, amin[sosl_pkg::SEC_RIGHT], 1'b0};
  assign safe7   = {1'b0, cfg.safety, 3'b0} - {4'b0, cfg.safety};
  assign halve   = (!ang_r[15] && ang_r != 16'sd0 && left10 < safe7) ||
                   (ang_r[15] && right10 < safe7);

  // halving truncates toward zero
  assign a17    = {ang_r[15], ang_r};
  assign ang_h  = halve ? ((a17 + $signed({16'b0, a17[16]})) >>> 1) : a17;
  assign ang_cl = sosl_pkg::clamp17(ang_h, cfg.max_turn);

  always_ff @(posedge clk) begin
    if (rst) begin
      beam_angle  <= '0;
      window_low  <= '0;
      window_high <= '0;
      scan_seen   <= 1'b0;
      out_valid   <= 1'b0;
      for (int i = 0; i < sosl_pkg::NUM_SEC; i++) begin
        bmin[i] <= sosl_pkg::NO_RETURN;
        amin[i] <= sosl_pkg::NO_RETURN;
      end
    end else begin
      if (cmd.take) begin
        case (operation)
          sosl_pkg::OP_HEADER: begin
            beam_angle  <= angle_start;
            window_low  <= range_low;
            window_high <= range_high;
            for (int i = 0; i < sosl_pkg::NUM_SEC; i++) begin
              bmin[i] <= sosl_pkg::NO_RETURN;
            end
          end
          sosl_pkg::OP_SAMPLE: begin
            for (int i = 0; i < sosl_pkg::NUM_SEC; i++) begin
              if (counts && hit[i] && range_value < bmin[i]) begin
                bmin[i] <= range_value;
              end
            end
            beam_angle <= beam_angle + angle_step;
          end
          sosl_pkg::OP_END: begin
            scan_seen <= 1'b1;
            for (int i = 0; i < sosl_pkg::NUM_SEC; i++) begin
              amin[i] <= bmin[i];
              bmin[i] <= sosl_pkg::NO_RETURN;
            end
          end
          default: ;
        endcase
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take && operation == sosl_pkg::OP_CMD) begin
      lin_r  <= linear_in;
      ang_r  <= angular_in;
      dist_r <= linear_in[15] ? amin[sosl_pkg::SEC_BACK] : amin[sosl_pkg::SEC_FRONT];
    end
    if (cmd.mul) begin
      red_zero <= zero_f;
      red_div  <= div_f;
      rem      <= prod[31:16];
      quo      <= prod[15:0];
    end else if (cmd.div_step) begin
      rem <= ge ? rem_sub[15:0] : rem_sh[15:0];
      quo <= {quo[14:0], ge};
    end
    if (cmd.load_out) begin
      linear_out  <= scan_seen ? lin_cl[15:0] : lin_r;
      angular_out <= scan_seen ? ang_cl[15:0] : ang_r;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/sosl_checker.sv -----
`default_nettype none

`include "sector_obstacle_speed_limiter_top_defines.svh"

module sosl_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic [1:0]         operation,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [15:0] linear_out,
  input wire logic signed [15:0] angular_out
);

  `SOSL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(linear_out) && $stable(angular_out), "result changed while stalled")
  `SOSL_ASSERT_NEXT(a_scan_one_cycle, in_valid && in_ready && operation != sosl_pkg::OP_CMD, in_ready, "scan request took more than one cycle")
  `SOSL_ASSERT_NEXT(a_cmd_busy, in_valid && in_ready && operation == sosl_pkg::OP_CMD, !in_ready, "input not held off during command")
  `SOSL_ASSERT_NOW(a_out_from_cmd, $rose(out_valid), !$past(in_ready), "result appeared without command work")

endmodule

bind sector_obstacle_speed_limiter_top sosl_checker u_sosl_checker (.*);

`default_nettype wire
